@@ rtl/evus_pkg.sv @@
package evus_pkg;

  localparam int unsigned ThrW    = 31;
  localparam int unsigned CountW  = 21;
  localparam int unsigned ChunkW  = 13;
  localparam int unsigned EnergyW = 43;
  localparam int unsigned SquareW = 31;
  localparam int unsigned ProdW   = ThrW + ChunkW;

  localparam logic [ThrW-1:0]   ThrReset   = ThrW'(160000);
  localparam logic [CountW-1:0] PauseReset = CountW'(8000);
  localparam logic [CountW-1:0] MaxReset   = CountW'(96000);
  localparam logic [ChunkW-1:0] ChunkReset = ChunkW'(3200);
  localparam logic [ChunkW-1:0] FillMax    = {ChunkW{1'b1}};
  localparam logic [CountW-1:0] CountMax   = {CountW{1'b1}};

  // Result queue: up to two results per item, three items can be in flight.
  localparam int unsigned QDepth = 8;
  localparam int unsigned QPtrW  = $clog2(QDepth);
  localparam int unsigned QCntW  = QPtrW + 1;

  typedef enum logic [1:0] {
    CFG_ENERGY_THRESHOLD      = 2'd0,
    CFG_PAUSE_SAMPLES         = 2'd1,
    CFG_MAX_UTTERANCE_SAMPLES = 2'd2,
    CFG_CHUNK_SAMPLES         = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic              chunk_speech;
    logic              chunk_kept;
    logic              flush;
    logic [CountW-1:0] segment_samples;
    logic              from_end_of_stream;
    logic              last_of_run;
  } result_t;

  // Saturating add of two 21-bit counts.
  function automatic logic [CountW-1:0] sat_add(input logic [CountW-1:0] a,
                                                input logic [CountW-1:0] b);
    logic [CountW:0] s;
    s = {1'b0, a} + {1'b0, b};
    sat_add = s[CountW] ? CountMax : s[CountW-1:0];
  endfunction

endpackage

@@ rtl/energy_vad_utterance_segmenter_core.sv @@
// Energy-based voice activity endpointing. Each input transaction carries one
// signed 16-bit PCM sample, or an end-of-stream marker. Squares are summed per
// chunk of chunk_samples samples, and a closed chunk is speech when its energy
// exceeds energy_threshold times its sample count. Every closed chunk gives one
// output transaction; end of stream can give a second one that flushes any
// pending utterance. The block takes one sample per clock cycle while the input
// is not stalled. A sample goes through two register stages (input square, then
// chunk accumulate with the threshold product). The utterance update and its
// results are written into an eight-entry result queue at the next clock edge,
// and the output is presented from the head of that queue. The input is stalled
// whenever the queue could not hold two results for every item in flight, so
// with the output drained each cycle the input never stalls; the two results of
// an end-of-stream transaction leave the queue one after the other.
module energy_vad_utterance_segmenter_core
  import evus_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // configuration write port
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [ThrW-1:0]      cfg_wdata_i,
  // input channel
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic signed [15:0]   sample_i,
  input  logic                 end_of_stream_i,
  // output channel
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 chunk_speech_o,
  output logic                 chunk_kept_o,
  output logic                 flush_o,
  output logic [CountW-1:0]    segment_samples_o,
  output logic                 from_end_of_stream_o,
  output logic                 last_of_run_o
);

  // Configuration registers.
  logic [ThrW-1:0]   thr_q;
  logic [CountW-1:0] pause_q;
  logic [CountW-1:0] max_q;
  logic [ChunkW-1:0] chunk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= ThrReset;
      pause_q <= PauseReset;
      max_q   <= MaxReset;
      chunk_q <= ChunkReset;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ENERGY_THRESHOLD:      thr_q   <= cfg_wdata_i;
        CFG_PAUSE_SAMPLES:         pause_q <= cfg_wdata_i[CountW-1:0];
        CFG_MAX_UTTERANCE_SAMPLES: max_q   <= cfg_wdata_i[CountW-1:0];
        CFG_CHUNK_SAMPLES:         chunk_q <= cfg_wdata_i[ChunkW-1:0];
        default: ;
      endcase
    end
  end

  // Result queue bookkeeping and input flow control.
  logic [QCntW-1:0] q_count_q;
  logic             s1_valid_q;
  logic             s2_valid_q;
  logic [1:0]       in_flight;
  logic [QCntW-1:0] q_free;
  logic             in_accept;

  // Every item in flight, plus the one offered, may need two queue entries.
  assign in_flight  = 2'(s1_valid_q) + 2'(s2_valid_q) + 2'd1;
  assign q_free     = QCntW'(QDepth) - q_count_q;
  assign in_stall_o = q_free < {{(QCntW-3){1'b0}}, in_flight, 1'b0};
  assign in_accept  = in_valid_i && !in_stall_o;

  // Stage 1: register the square of the sample.
  logic signed [31:0] square_full;
  logic [SquareW-1:0] s1_square_q;
  logic               s1_eos_q;

  assign square_full = 32'(sample_i) * 32'(sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_square_q <= square_full[SquareW-1:0];
      s1_eos_q    <= end_of_stream_i;
    end
  end

  // Stage 2: chunk accumulation. A closing chunk hands its energy, its sample
  // count and the threshold product to the utterance stage.
  logic [EnergyW-1:0] energy_q;
  logic [EnergyW-1:0] energy_d;
  logic [ChunkW-1:0]  fill_q;
  logic [ChunkW-1:0]  fill_d;
  logic [ChunkW-1:0]  chunk_len;
  logic [ChunkW-1:0]  fill_inc;
  logic [EnergyW-1:0] energy_inc;
  logic               close;
  logic [ChunkW-1:0]  close_n;
  logic [EnergyW-1:0] close_energy;

  logic               s2_eos_q;
  logic               s2_close_q;
  logic [ChunkW-1:0]  s2_n_q;
  logic [EnergyW-1:0] s2_energy_q;
  logic [ProdW-1:0]   s2_prod_q;

  always_comb begin
    // A chunk length of zero behaves as one sample.
    chunk_len    = (chunk_q == '0) ? ChunkW'(1) : chunk_q;
    fill_inc     = (fill_q == FillMax) ? fill_q : fill_q + ChunkW'(1);
    energy_inc   = energy_q + EnergyW'(s1_square_q);
    energy_d     = energy_q;
    fill_d       = fill_q;
    close        = 1'b0;
    close_n      = fill_inc;
    close_energy = energy_inc;
    if (s1_valid_q) begin
      if (!s1_eos_q) begin
        close = fill_inc >= chunk_len;
        if (close) begin
          energy_d = '0;
          fill_d   = '0;
        end else begin
          energy_d = energy_inc;
          fill_d   = fill_inc;
        end
      end else begin
        // End of stream closes a partial chunk, if any.
        close        = fill_q != '0;
        close_n      = fill_q;
        close_energy = energy_q;
        energy_d     = '0;
        fill_d       = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      energy_q   <= '0;
      fill_q     <= '0;
      s2_valid_q <= 1'b0;
    end else begin
      energy_q   <= energy_d;
      fill_q     <= fill_d;
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      s2_eos_q    <= s1_eos_q;
      s2_close_q  <= close;
      s2_n_q      <= close_n;
      s2_energy_q <= close_energy;
      s2_prod_q   <= ProdW'(thr_q) * ProdW'(close_n);
    end
  end

  // Stage 3: utterance tracking and result generation.
  logic [CountW-1:0] utt_q, utt_d;
  logic [CountW-1:0] sil_q, sil_d;
  logic [CountW-1:0] keep_q, keep_d;
  logic              seen_q, seen_d;
  logic              pend_q, pend_d;

  logic              speech;
  logic              kept;
  logic              flush_chunk;
  logic [CountW-1:0] seg_chunk;
  logic [CountW-1:0] n21;
  logic              flush_eos;
  result_t           res_a;
  result_t           res_b;
  logic              wr_a;
  logic              wr_b;

  always_comb begin
    n21         = CountW'(s2_n_q);
    speech      = {1'b0, s2_energy_q} > s2_prod_q;
    kept        = seen_q || speech;
    flush_chunk = 1'b0;
    seg_chunk   = '0;
    utt_d       = utt_q;
    sil_d       = sil_q;
    keep_d      = keep_q;
    seen_d      = seen_q;
    pend_d      = pend_q;
    wr_a        = 1'b0;
    wr_b        = 1'b0;
    flush_eos   = 1'b0;

    if (s2_valid_q && s2_close_q) begin
      wr_a = 1'b1;
      if (kept) begin
        utt_d = sat_add(utt_q, n21);
        if (speech) begin
          seen_d = 1'b1;
          sil_d  = '0;
          keep_d = utt_d;
          pend_d = 1'b1;
        end else begin
          sil_d = sat_add(sil_q, n21);
          if (pend_q) begin
            keep_d = utt_d;
            pend_d = 1'b0;
          end
        end
        if (sil_d >= pause_q || utt_d >= max_q) begin
          flush_chunk = 1'b1;
          seg_chunk   = keep_d;
          utt_d       = '0;
          sil_d       = '0;
          keep_d      = '0;
          seen_d      = 1'b0;
          pend_d      = 1'b0;
        end
      end
    end

    // End of stream flushes whatever speech is still pending.
    res_b = '{chunk_speech: 1'b0, chunk_kept: 1'b0, flush: 1'b1,
              segment_samples: keep_d, from_end_of_stream: 1'b1,
              last_of_run: 1'b1};
    if (s2_valid_q && s2_eos_q && seen_d) begin
      flush_eos = 1'b1;
      utt_d     = '0;
      sil_d     = '0;
      keep_d    = '0;
      seen_d    = 1'b0;
      pend_d    = 1'b0;
    end

    res_a = '{chunk_speech: speech, chunk_kept: kept, flush: flush_chunk,
              segment_samples: seg_chunk, from_end_of_stream: s2_eos_q,
              last_of_run: !flush_eos};

    if (flush_eos) begin
      if (wr_a) begin
        wr_b = 1'b1;
      end else begin
        // The flush is the only result, so it takes the first queue slot.
        wr_a  = 1'b1;
        res_a = res_b;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      utt_q  <= '0;
      sil_q  <= '0;
      keep_q <= '0;
      seen_q <= 1'b0;
      pend_q <= 1'b0;
    end else begin
      utt_q  <= utt_d;
      sil_q  <= sil_d;
      keep_q <= keep_d;
      seen_q <= seen_d;
      pend_q <= pend_d;
    end
  end

  // Result queue: two write slots per cycle, one read at the head.
  result_t          q_mem_q [QDepth];
  logic [QPtrW-1:0] q_wptr_q;
  logic [QPtrW-1:0] q_rptr_q;
  logic [QPtrW-1:0] q_wptr_next;
  logic             q_pop;
  result_t          q_head;

  assign q_wptr_next = q_wptr_q + QPtrW'(1);
  assign out_valid_o = q_count_q != '0;
  assign q_pop       = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_wptr_q  <= '0;
      q_rptr_q  <= '0;
      q_count_q <= '0;
    end else begin
      q_wptr_q  <= q_wptr_q + QPtrW'(wr_a) + QPtrW'(wr_b);
      q_rptr_q  <= q_rptr_q + QPtrW'(q_pop);
      q_count_q <= q_count_q + QCntW'(wr_a) + QCntW'(wr_b) - QCntW'(q_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_a) begin
      q_mem_q[q_wptr_q] <= res_a;
    end
    if (wr_b) begin
      q_mem_q[q_wptr_next] <= res_b;
    end
  end

  assign q_head               = q_mem_q[q_rptr_q];
  assign chunk_speech_o       = q_head.chunk_speech;
  assign chunk_kept_o         = q_head.chunk_kept;
  assign flush_o              = q_head.flush;
  assign segment_samples_o    = q_head.segment_samples;
  assign from_end_of_stream_o = q_head.from_end_of_stream;
  assign last_of_run_o        = q_head.last_of_run;

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import evus_pkg::*;

  // Cycles to let pass once every awaited result is back, so that an item
  // that causes no result (a sample that does not close a chunk, or an end of
  // stream with nothing pending) has left the three-stage pipeline before any
  // register is written.
  localparam int SETTLE_CYCLES = 10;
  // The longest correct stretch without any transaction is the forced output
  // hold-off of the backpressure test; allow several times that.
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_PERCENT = 23;
  localparam int RANDOM_SAMPLES = 1200;
  localparam int FULL_SCALE_CHUNK = 64;
  localparam logic signed [15:0] PCM_MIN = 16'sh8000;
  localparam logic signed [15:0] PCM_MAX = 16'sh7FFF;

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  cfg_reg_e                 cfg_idx;
  logic [ThrW-1:0]          cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [15:0]       pcm_sample;
  logic                     stream_end;
  logic                     out_valid;
  logic                     out_stall;
  logic                     res_speech;
  logic                     res_kept;
  logic                     res_flush;
  logic [CountW-1:0]        res_segment;
  logic                     res_from_eos;
  logic                     res_last;

  energy_vad_utterance_segmenter_core DUT (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .cfg_we_i            (cfg_we),
    .cfg_idx_i           (cfg_idx),
    .cfg_wdata_i         (cfg_wdata),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .sample_i            (pcm_sample),
    .end_of_stream_i     (stream_end),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .chunk_speech_o      (res_speech),
    .chunk_kept_o        (res_kept),
    .flush_o             (res_flush),
    .segment_samples_o   (res_segment),
    .from_end_of_stream_o(res_from_eos),
    .last_of_run_o       (res_last)
  );

  // Shared run state. When no_idle is set, neither side inserts idle cycles.
  // hold_off is loaded by a test and counted down by the stall process.
  bit       no_idle;
  int       hold_off;
  int       mismatch_count;
  int       samples_sent;
  result_t  awaited_results[$];

  // ---------------------------------------------------------------------------
  // Segmenter predictor. It mirrors the configuration registers and the
  // per-chunk and per-utterance state of the block, and turns every accepted
  // input transaction into the output transactions it must cause.
  // ---------------------------------------------------------------------------
  logic [ThrW-1:0]    cfg_threshold;
  logic [CountW-1:0]  cfg_pause;
  logic [CountW-1:0]  cfg_max_utt;
  logic [ChunkW-1:0]  cfg_chunk;

  logic [EnergyW-1:0] acc_energy;
  logic [ChunkW-1:0]  acc_count;
  logic [CountW-1:0]  utt_samples;
  logic [CountW-1:0]  quiet_samples;
  logic [CountW-1:0]  kept_samples;
  logic               in_utterance;
  logic               tail_pending;

  function automatic logic [CountW-1:0] count_up(input logic [CountW-1:0] acc,
                                                 input logic [CountW-1:0] inc);
    logic [CountW:0] wide;
    wide = acc + inc;
    return (wide > CountMax) ? CountMax : wide[CountW-1:0];
  endfunction

  function automatic void end_utterance();
    utt_samples   = '0;
    quiet_samples = '0;
    kept_samples  = '0;
    in_utterance  = 1'b0;
    tail_pending  = 1'b0;
  endfunction

  // Classifies the chunk collected so far and updates the utterance. A chunk
  // is speech when its energy strictly exceeds threshold times its length.
  function automatic result_t classify_chunk(input logic eos);
    result_t           r;
    logic [ChunkW-1:0] n;
    logic [63:0]       bar;
    logic              speech;
    logic              kept;
    n      = acc_count;
    bar    = 64'(cfg_threshold) * 64'(n);
    speech = {21'b0, acc_energy} > bar;
    kept   = in_utterance || speech;
    r      = '0;
    r.chunk_speech       = speech;
    r.chunk_kept         = kept;
    r.from_end_of_stream = eos;
    acc_energy = '0;
    acc_count  = '0;
    if (kept) begin
      utt_samples = count_up(utt_samples, CountW'(n));
      if (speech) begin
        in_utterance  = 1'b1;
        quiet_samples = '0;
        kept_samples  = utt_samples;
        tail_pending  = 1'b1;
      end else begin
        quiet_samples = count_up(quiet_samples, CountW'(n));
        // The first silence chunk after speech is kept as a tail.
        if (tail_pending) begin
          kept_samples = utt_samples;
          tail_pending = 1'b0;
        end
      end
      if (quiet_samples >= cfg_pause || utt_samples >= cfg_max_utt) begin
        r.flush           = 1'b1;
        r.segment_samples = kept_samples;
        end_utterance();
      end
    end
    return r;
  endfunction

  task automatic predict_segmenter(input logic signed [15:0] s, input logic eos);
    result_t           produced[$];
    result_t           r;
    int                magnitude;
    logic [ChunkW-1:0] span;
    if (!eos) begin
      magnitude  = (s < 0) ? -int'(s) : int'(s);
      acc_energy = acc_energy + EnergyW'(longint'(magnitude) * longint'(magnitude));
      if (acc_count != FillMax) acc_count = acc_count + ChunkW'(1);
      // A chunk length of zero behaves as one; a fill left above a lowered
      // chunk length closes on this sample.
      span = (cfg_chunk == '0) ? ChunkW'(1) : cfg_chunk;
      if (acc_count >= span) produced = {produced, classify_chunk(1'b0)};
    end else begin
      if (acc_count != '0) produced = {produced, classify_chunk(1'b1)};
      if (in_utterance) begin
        r                    = '0;
        r.flush              = 1'b1;
        r.segment_samples    = kept_samples;
        r.from_end_of_stream = 1'b1;
        produced = {produced, r};
        end_utterance();
      end
    end
    if (produced.size() > 0) begin
      produced[produced.size() - 1].last_of_run = 1'b1;
    end
    awaited_results = {awaited_results, produced};
  endtask

  // ---------------------------------------------------------------------------
  // Clock, output stall, result checking and watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, except during a hold-off, when it stalls
  // every cycle, and during a stretch without idling.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off > 0) begin
        out_stall <= 1'b1;
        hold_off--;
      end else if (no_idle) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < IDLE_PERCENT);
      end
    end
  end

  function automatic void check_field(input string name, input logic [CountW-1:0] want,
                                      input logic [CountW-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10) begin
        $display("%0t: %s expected %0d got %0d", $realtime, name, want, got);
      end
    end
  endfunction

  // Every output transaction is compared with the oldest awaited result.
  initial begin
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t: output transaction with no result awaited", $realtime);
          end
        end else begin
          want = awaited_results.pop_front();
          check_field("chunk_speech", CountW'(want.chunk_speech), CountW'(res_speech));
          check_field("chunk_kept", CountW'(want.chunk_kept), CountW'(res_kept));
          check_field("flush", CountW'(want.flush), CountW'(res_flush));
          check_field("segment_samples", want.segment_samples, res_segment);
          check_field("from_end_of_stream", CountW'(want.from_end_of_stream),
                      CountW'(res_from_eos));
          check_field("last_of_run", CountW'(want.last_of_run), CountW'(res_last));
        end
      end
    end
  end

  // Ends the run when no transaction on either channel happens for too long.
  initial begin
    int stuck_cycles;
    stuck_cycles = 0;
    while (stuck_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid === 1'b1 && in_stall === 1'b0) ||
          (out_valid === 1'b1 && out_stall === 1'b0)) begin
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("%0t: watchdog expired", $realtime);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sender side. Every task is entered and left at a falling edge. send_item
  // leaves valid high so that items can be sent back to back; wait_for_drain
  // lowers valid first, and every register write follows a drain.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic signed [15:0] s, input logic eos);
    while (!no_idle && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    pcm_sample <= s;
    stream_end <= eos;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    predict_segmenter(s, eos);
    samples_sent++;
    @(negedge clk);
  endtask

  // Sends n samples that are all loud or all near zero, with random signs.
  task automatic send_chunk(input bit loud, input int n);
    int mag;
    repeat (n) begin
      mag = loud ? $urandom_range(32767, 2100) : $urandom_range(9, 0);
      send_item(($urandom_range(1) != 0) ? 16'(-mag) : 16'(mag), 1'b0);
    end
  endtask

  // Waits until every awaited result is back and the pipeline is empty.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Register writes happen only with the block drained.
  task automatic write_reg(input cfg_reg_e idx, input logic [ThrW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    case (idx)
      CFG_ENERGY_THRESHOLD:      cfg_threshold = value;
      CFG_PAUSE_SAMPLES:         cfg_pause     = value[CountW-1:0];
      CFG_MAX_UTTERANCE_SAMPLES: cfg_max_utt   = value[CountW-1:0];
      default:                   cfg_chunk     = value[ChunkW-1:0];
    endcase
  endtask

  task automatic set_config(input logic [ThrW-1:0] thr, input logic [CountW-1:0] pause,
                            input logic [CountW-1:0] max_utt, input logic [ChunkW-1:0] chunk);
    write_reg(CFG_ENERGY_THRESHOLD, thr);
    write_reg(CFG_PAUSE_SAMPLES, ThrW'(pause));
    write_reg(CFG_MAX_UTTERANCE_SAMPLES, ThrW'(max_utt));
    write_reg(CFG_CHUNK_SAMPLES, ThrW'(chunk));
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset settings: a short partial chunk, mostly of full-scale samples, is closed
  // by end of stream, which then flushes the utterance. A second end of stream
  // finds nothing pending and must give no result.
  task automatic test_reset_settings();
    send_item(PCM_MAX, 1'b0);
    send_item(PCM_MIN, 1'b0);
    send_item(16'sd400, 1'b0);
    send_item(16'sd0, 1'b1);
    send_item(16'sd0, 1'b1);
    wait_for_drain();
  endtask

  // Zero settings: a chunk length of zero closes a chunk on every sample, and
  // with pause and maximum at zero every kept chunk flushes at once. A zero
  // sample has no energy and is never speech, even at threshold zero.
  task automatic test_zero_settings();
    set_config('0, '0, '0, '0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd0, 1'b0);
    wait_for_drain();
  endtask

  // Pause, tail chunk, end of stream and maximum length, on two-sample chunks.
  task automatic test_endpointing();
    set_config(ThrW'(1000), CountW'(4), CountMax, ChunkW'(2));
    // Speech, then silence until the pause is reached: the flushed length
    // covers the speech chunk and one silence chunk.
    send_item(PCM_MIN, 1'b0);
    send_item(PCM_MAX, 1'b0);
    send_item(16'sd0, 1'b0);
    send_item(-16'sd1, 1'b0);
    send_item(16'sd1, 1'b0);
    send_item(16'sd0, 1'b0);
    // Speech, a partial quiet chunk, then end of stream: the partial chunk
    // closes and a flush follows it.
    send_item(16'sh4000, 1'b0);
    send_item(16'shC000, 1'b0);
    send_item(16'sd3, 1'b0);
    send_item(16'sd0, 1'b1);
    // End of stream right on a chunk boundary gives only the flush.
    send_item(16'sh7000, 1'b0);
    send_item(-16'sd9000, 1'b0);
    send_item(PCM_MIN, 1'b1);
    wait_for_drain();
    // Maximum length forces the flush.
    write_reg(CFG_MAX_UTTERANCE_SAMPLES, ThrW'(4));
    send_chunk(1'b1, 4);
    wait_for_drain();
  endtask

  // A fill left above a lowered chunk length closes on the next sample.
  task automatic test_lowered_chunk();
    set_config(ThrW'(100), CountW'(8), CountW'(64), ChunkW'(16));
    send_chunk(1'b1, 10);
    wait_for_drain();
    write_reg(CFG_CHUNK_SAMPLES, ThrW'(3));
    send_chunk(1'b0, 1);
    send_item(16'sd0, 1'b1);
    wait_for_drain();
  endtask

  // The receiver holds off for a long stretch while samples keep coming, so
  // the result queue fills and the block stalls its input.
  task automatic test_output_backpressure();
    set_config(ThrW'(1000), CountW'(3), CountW'(50), ChunkW'(1));
    hold_off = HOLD_CYCLES;
    repeat (80) send_chunk(1'($urandom_range(1)), 1);
    wait_for_drain();
  endtask

  task automatic randomize_settings(output int span);
    logic [ThrW-1:0]   thr;
    logic [CountW-1:0] pause;
    logic [CountW-1:0] max_utt;
    logic [ChunkW-1:0] chunk;
    int                roll;
    roll  = $urandom_range(99);
    chunk = (roll < 5) ? '0 : (roll < 12) ? ChunkW'($urandom_range(64, 20))
                                          : ChunkW'($urandom_range(12, 1));
    span  = (chunk == '0) ? 1 : int'(chunk);
    roll  = $urandom_range(99);
    thr   = (roll < 5) ? '0 : (roll < 8) ? {ThrW{1'b1}}
                                         : ThrW'($urandom_range(4000000, 100));
    roll  = $urandom_range(99);
    pause = (roll < 6) ? '0 : (roll < 10) ? CountMax
                                          : CountW'($urandom_range(6 * span, 1));
    roll  = $urandom_range(99);
    max_utt = (roll < 6) ? '0 : (roll < 10) ? CountMax
                                            : CountW'($urandom_range(40 * span, 1));
    set_config(thr, pause, max_utt, chunk);
  endtask

  // Random utterances: leading silence, speech, trailing silence and
  // sometimes a partial chunk closed by end of stream, mixed with raw noise
  // transactions. Settings change between phases; one phase runs without
  // idle cycles on either side.
  task automatic test_random_utterances();
    int goal;
    int phase;
    int span;
    goal  = samples_sent + RANDOM_SAMPLES;
    phase = 0;
    while (samples_sent < goal) begin
      wait_for_drain();
      no_idle = (phase == 1);
      randomize_settings(span);
      repeat ($urandom_range(14, 4)) begin
        if (samples_sent >= goal) break;
        repeat ($urandom_range(2, 0)) send_chunk(1'b0, span);
        repeat ($urandom_range(4, 1)) send_chunk(1'b1, span);
        repeat ($urandom_range(3, 0)) send_chunk(1'b0, span);
        if ($urandom_range(99) < 15) begin
          repeat ($urandom_range(6, 1)) begin
            send_item(16'($urandom), ($urandom_range(99) < 10));
          end
        end
        if ($urandom_range(99) < 20) begin
          send_chunk(1'($urandom_range(1)), $urandom_range(span - 1, 0));
          send_item(16'($urandom), 1'b1);
        end
      end
      phase++;
    end
    no_idle = 1'b0;
    wait_for_drain();
  endtask

  // Full-scale samples: a chunk whose energy is just above the bar is speech,
  // and a chunk whose energy equals the bar exactly is not.
  task automatic test_full_scale_chunks();
    set_config(ThrW'(32'h3FFF_FFFF), CountMax, CountMax, ChunkW'(FULL_SCALE_CHUNK));
    repeat (FULL_SCALE_CHUNK) send_item(PCM_MIN, 1'b0);
    send_item(16'sd0, 1'b1);
    wait_for_drain();
    set_config(ThrW'(32'h4000_0000), CountW'(1), CountMax, ChunkW'(FULL_SCALE_CHUNK));
    repeat (FULL_SCALE_CHUNK) send_item(PCM_MIN, 1'b0);
    wait_for_drain();
  endtask

  initial begin
    in_valid       = 1'b0;
    pcm_sample     = '0;
    stream_end     = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_ENERGY_THRESHOLD;
    cfg_wdata      = '0;
    no_idle        = 1'b0;
    hold_off       = 0;
    mismatch_count = 0;
    samples_sent   = 0;
    cfg_threshold  = ThrReset;
    cfg_pause      = PauseReset;
    cfg_max_utt    = MaxReset;
    cfg_chunk      = ChunkReset;
    acc_energy     = '0;
    acc_count      = '0;
    end_utterance();
    rst_n = 1'b0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    test_reset_settings();
    test_zero_settings();
    test_endpointing();
    test_lowered_chunk();
    test_output_backpressure();
    test_random_utterances();
    test_full_scale_chunks();

    wait_for_drain();
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
